@@ design/lsb_variable_depth_embed_core_macros.svh @@
// assertion macros shared by the embed core
`ifndef LSB_VARIABLE_DEPTH_EMBED_CORE_MACROS_SVH
`define LSB_VARIABLE_DEPTH_EMBED_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define LVDE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define LVDE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/lvde_pkg.sv @@
// types and constants of the variable depth lsb embed core
`timescale 1ns / 1ps

package lvde_pkg;

    localparam int COUNT_BITS = 32;
    localparam int CMP_W      = (COUNT_BITS > 32) ? COUNT_BITS : 32;
    localparam int ACC_W      = CMP_W + 4;
    localparam int SKIP_W     = 34;

    typedef logic [COUNT_BITS-1:0] t_count;

    typedef enum logic [2:0] {
        ST_EMBED     = 3'd0,
        ST_PASS      = 3'd1,
        ST_ZERO_FILL = 3'd2,
        ST_ACCEPTED  = 3'd3,
        ST_DROPPED   = 3'd4
    } t_status;

    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_COVER = 1'b1;

    typedef logic [2:0] t_cfg_index;

    localparam t_cfg_index CFG_BITS_BLUE     = 3'd0;
    localparam t_cfg_index CFG_BITS_GREEN    = 3'd1;
    localparam t_cfg_index CFG_BITS_RED      = 3'd2;
    localparam t_cfg_index CFG_SKIP_PIXELS   = 3'd3;
    localparam t_cfg_index CFG_SECRET_TOTAL  = 3'd4;
    localparam t_cfg_index CFG_PAYLOAD_LIMIT = 3'd5;

    localparam logic [3:0] MAX_DEPTH = 4'd8;

endpackage

@@ design/lsb_variable_depth_embed_core.sv @@
// lsb embed core: hides secret bits in cover channel bytes, depth per color phase
`timescale 1ns / 1ps
//
// input channel: i_in_valid / o_in_stall carry one word per accept, i_opcode
//   selects a secret byte push or a cover channel byte, i_data_byte holds it
// output channel: o_out_valid / i_out_stall carry one result word per input
//   word: o_out_byte (modified cover byte, zero for a push) and o_status
// config channel: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data,
//   always ready; write only while no word is in flight
// result: the result of an accepted word loads the result register at the accept
// throughput: one word per cycle when not stalled, set by the single result register;
//   state (bit buffer, counters, color phase, skip count) updates at the accept
// stall: while the result register is full and the receiver stalls, the input
//   is stalled too; the held result does not change
// reset: i_rst_n low at an edge clears all state, sets the three depths to one
//   and the other registers to zero, and empties the result register
//
`include "lsb_variable_depth_embed_core_macros.svh"

module lsb_variable_depth_embed_core
    import lvde_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input word
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_opcode,
    input  logic [7:0]  i_data_byte,
    // result word
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic [2:0]  o_status,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  t_cfg_index  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    // configuration registers
    logic [3:0]  r_bits_blue;
    logic [3:0]  r_bits_green;
    logic [3:0]  r_bits_red;
    logic [31:0] r_skip_pixels;
    logic [31:0] r_secret_total;
    logic [31:0] r_payload_limit;

    // embedding state
    logic [15:0]       r_bit_buffer,    n_bit_buffer;
    logic [4:0]        r_bits_held,     n_bits_held;
    logic [2:0]        r_bits_into_byte, n_bits_into_byte;
    t_count            r_bytes_consumed, n_bytes_consumed;
    t_count            r_channels_seen, n_channels_seen;
    logic [1:0]        r_color_phase,   n_color_phase;
    logic [SKIP_W-1:0] r_skip_remaining, n_skip_remaining;

    // result register
    logic       r_out_valid;
    logic [7:0] r_out_byte,  n_out_byte;
    t_status    r_status,    n_status;

    logic in_accept;

    // datapath intermediates
    logic [ACC_W-1:0]  accounted;
    logic [ACC_W-1:0]  total_bits;
    logic [3:0]        raw_depth;
    logic [3:0]        depth;
    logic [3:0]        take;
    logic [4:0]        held_after;
    logic [15:0]       shifted;
    logic [7:0]        take_mask;
    logic [7:0]        field;
    logic [15:0]       keep_mask;
    logic [7:0]        low_mask;
    logic [3:0]        byte_pos_sum;
    logic [SKIP_W-1:0] skip_load;
    logic              payload_done;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_status    = r_status;

    // config writes, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits_blue     <= 4'd1;
            r_bits_green    <= 4'd1;
            r_bits_red      <= 4'd1;
            r_skip_pixels   <= '0;
            r_secret_total  <= '0;
            r_payload_limit <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_BITS_BLUE:     r_bits_blue     <= i_cfg_data[3:0];
                CFG_BITS_GREEN:    r_bits_green    <= i_cfg_data[3:0];
                CFG_BITS_RED:      r_bits_red      <= i_cfg_data[3:0];
                CFG_SKIP_PIXELS:   r_skip_pixels   <= i_cfg_data;
                CFG_SECRET_TOTAL:  r_secret_total  <= i_cfg_data;
                CFG_PAYLOAD_LIMIT: r_payload_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // shared datapath terms
    always_comb begin
        // bits already spoken for: consumed bytes, partial byte, buffered bits
        accounted  = ACC_W'({r_bytes_consumed, r_bits_into_byte}) + ACC_W'(r_bits_held);
        total_bits = ACC_W'({r_secret_total, 3'b000});

        unique case (r_color_phase)
            2'd0:    raw_depth = r_bits_blue;
            2'd1:    raw_depth = r_bits_green;
            default: raw_depth = r_bits_red;
        endcase
        depth = (raw_depth > MAX_DEPTH) ? MAX_DEPTH : raw_depth;

        // underflow takes what is held and zero-fills the rest
        take       = (r_bits_held < {1'b0, depth}) ? r_bits_held[3:0] : depth;
        held_after = r_bits_held - {1'b0, take};
        shifted    = r_bit_buffer >> held_after;
        take_mask  = 8'((9'd1 << take) - 9'd1);
        field      = (shifted[7:0] & take_mask) << (depth - take);
        keep_mask  = 16'((17'd1 << held_after) - 17'd1);
        low_mask   = 8'((9'd1 << depth) - 9'd1);

        byte_pos_sum = {1'b0, r_bits_into_byte} + depth;
        skip_load    = SKIP_W'(r_skip_pixels) + SKIP_W'({r_skip_pixels, 1'b0});

        payload_done = (CMP_W'(r_bytes_consumed) >= CMP_W'(r_secret_total)) ||
                       (CMP_W'(r_channels_seen)  >= CMP_W'(r_payload_limit));
    end

    // next state and result for the word at the input
    always_comb begin
        n_bit_buffer     = r_bit_buffer;
        n_bits_held      = r_bits_held;
        n_bits_into_byte = r_bits_into_byte;
        n_bytes_consumed = r_bytes_consumed;
        n_channels_seen  = r_channels_seen;
        n_color_phase    = r_color_phase;
        n_skip_remaining = r_skip_remaining;
        n_out_byte       = 8'd0;
        n_status         = ST_PASS;

        if (i_opcode == OP_PUSH) begin
            // push: dropped when buffer is past one byte or total is reached
            if (r_bits_held > 5'd8 || accounted >= total_bits) begin
                n_status = ST_DROPPED;
            end else begin
                n_bit_buffer = {r_bit_buffer[7:0], i_data_byte};
                n_bits_held  = r_bits_held + 5'd8;
                n_status     = ST_ACCEPTED;
            end
        end else begin
            n_out_byte = i_data_byte;
            if (r_channels_seen != {COUNT_BITS{1'b1}}) begin
                n_channels_seen = r_channels_seen + 1'b1;
            end
            if (!payload_done) begin
                if (r_skip_remaining != '0) begin
                    n_skip_remaining = r_skip_remaining - 1'b1;
                end else begin
                    if (depth != 4'd0) begin
                        if (take != 4'd0) begin
                            n_bits_held  = held_after;
                            n_bit_buffer = r_bit_buffer & keep_mask;
                        end
                        n_out_byte = (i_data_byte & ~low_mask) | field;
                        n_status   = (take < depth) ? ST_ZERO_FILL : ST_EMBED;
                        if (byte_pos_sum[3] && r_bytes_consumed != {COUNT_BITS{1'b1}}) begin
                            n_bytes_consumed = r_bytes_consumed + 1'b1;
                        end
                        n_bits_into_byte = byte_pos_sum[2:0];
                    end
                    // end of pixel reloads the skip count
                    if (r_color_phase >= 2'd2) begin
                        n_color_phase    = 2'd0;
                        n_skip_remaining = skip_load;
                    end else begin
                        n_color_phase = r_color_phase + 2'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_buffer     <= '0;
            r_bits_held      <= '0;
            r_bits_into_byte <= '0;
            r_bytes_consumed <= '0;
            r_channels_seen  <= '0;
            r_color_phase    <= '0;
            r_skip_remaining <= '0;
        end else if (in_accept) begin
            r_bit_buffer     <= n_bit_buffer;
            r_bits_held      <= n_bits_held;
            r_bits_into_byte <= n_bits_into_byte;
            r_bytes_consumed <= n_bytes_consumed;
            r_channels_seen  <= n_channels_seen;
            r_color_phase    <= n_color_phase;
            r_skip_remaining <= n_skip_remaining;
        end
    end

    // result register, loads whenever it is free or being taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_out_valid <= in_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_byte <= n_out_byte;
            r_status   <= n_status;
        end
    end

    `LVDE_ASSERT_NEXT(a_full_push_drops,
        in_accept && i_opcode == OP_PUSH && r_bits_held > 5'd8,
        o_out_valid && o_status == ST_DROPPED,
        "push into a full bit buffer was not dropped")

    `LVDE_ASSERT_NEXT(a_skip_passes,
        in_accept && i_opcode == OP_COVER && r_skip_remaining != '0,
        o_status == ST_PASS && o_out_byte == $past(i_data_byte),
        "cover byte changed during a skip")

    `LVDE_ASSERT_NEXT(a_channel_count,
        in_accept && i_opcode == OP_COVER && r_channels_seen != {COUNT_BITS{1'b1}},
        r_channels_seen == $past(r_channels_seen) + 1'b1,
        "channel count did not advance on a cover byte")

    `LVDE_ASSERT_NOW(a_held_bound,
        o_out_valid,
        r_bits_held <= 5'd16 && r_bits_into_byte <= 3'd7,
        "bit buffer holds more than sixteen bits")

endmodule

@@ sim/tb.sv @@
// self-checking testbench for the variable depth lsb embed core
`timescale 1ns / 1ps

module tb;
    import lvde_pkg::*;

    // one expected result word
    typedef struct packed {
        logic [7:0] out_byte;
        t_status    status;
    } t_embed_result;

    // tracks the embed state and the result words still owed by the core
    class embed_scoreboard;
        logic [3:0]    depth_blue, depth_green, depth_red;
        logic [31:0]   skip_pixels, secret_total, payload_limit;
        logic [15:0]   bit_buffer;
        logic [4:0]    bits_held;
        logic [2:0]    bits_into_byte;
        t_count        bytes_used, channels_seen;
        logic [1:0]    color_phase;
        logic [33:0]   skip_left;
        t_embed_result owed_results [$];
        int unsigned   errors;

        function new();
            depth_blue     = 4'd1;
            depth_green    = 4'd1;
            depth_red      = 4'd1;
            skip_pixels    = '0;
            secret_total   = '0;
            payload_limit  = '0;
            bit_buffer     = '0;
            bits_held      = '0;
            bits_into_byte = '0;
            bytes_used     = '0;
            channels_seen  = '0;
            color_phase    = '0;
            skip_left      = '0;
            errors         = 0;
        endfunction

        function void set_reg(t_cfg_index idx, logic [31:0] val);
            case (idx)
                CFG_BITS_BLUE:     depth_blue    = val[3:0];
                CFG_BITS_GREEN:    depth_green   = val[3:0];
                CFG_BITS_RED:      depth_red     = val[3:0];
                CFG_SKIP_PIXELS:   skip_pixels   = val;
                CFG_SECRET_TOTAL:  secret_total  = val;
                CFG_PAYLOAD_LIMIT: payload_limit = val;
                default: ;
            endcase
        endfunction

        // depth of the current color phase, anything above eight counts as eight
        function int unsigned phase_depth();
            logic [3:0] d;
            d = (color_phase == 2'd0) ? depth_blue :
                (color_phase == 2'd1) ? depth_green : depth_red;
            return (d > MAX_DEPTH) ? int'(MAX_DEPTH) : int'(d);
        endfunction

        // accepted input word: update state and queue the result it causes
        function void note_word(logic op, logic [7:0] data);
            t_embed_result want;
            logic [63:0]   accounted;
            logic          done;
            logic [7:0]    lowmask;
            int unsigned   n, k, fld, c;
            want.out_byte = data;
            want.status   = ST_PASS;
            if (op == OP_PUSH) begin
                accounted = 64'(bytes_used) * 64'd8 + 64'(bits_into_byte) + 64'(bits_held);
                want.out_byte = 8'h00;
                if (bits_held > 5'd8 || accounted >= 64'(secret_total) * 64'd8) begin
                    want.status = ST_DROPPED;
                end else begin
                    bit_buffer  = {bit_buffer[7:0], data};
                    bits_held   = bits_held + 5'd8;
                    want.status = ST_ACCEPTED;
                end
            end else begin
                done = (bytes_used >= secret_total) || (channels_seen >= payload_limit);
                if (channels_seen != '1) channels_seen++;
                if (!done) begin
                    if (skip_left != 0) begin
                        skip_left--;
                    end else begin
                        n = phase_depth();
                        if (n != 0) begin
                            k   = (int'(bits_held) < n) ? int'(bits_held) : n;
                            fld = 0;
                            if (k != 0) begin
                                // oldest bits sit at the top of the held bits
                                fld = (int'(bit_buffer) >> (int'(bits_held) - k))
                                      & ((1 << k) - 1);
                                fld = fld << (n - k);
                                bits_held  = bits_held - 5'(k);
                                bit_buffer = bit_buffer & 16'((1 << bits_held) - 1);
                            end
                            lowmask       = 8'((1 << n) - 1);
                            want.out_byte = (data & ~lowmask) | 8'(fld);
                            want.status   = (k < n) ? ST_ZERO_FILL : ST_EMBED;
                            c = int'(bits_into_byte) + n;
                            if (c >= 8 && bytes_used != '1) bytes_used++;
                            bits_into_byte = 3'(c);
                        end
                        color_phase++;
                        if (color_phase >= 2'd3) begin
                            color_phase = 2'd0;
                            skip_left   = 34'(skip_pixels) * 34'd3;
                        end
                    end
                end
            end
            owed_results.push_back(want);
        endfunction

        // accepted result word: compare with the oldest owed result
        function void check_word(logic [7:0] got_byte, logic [2:0] got_status);
            t_embed_result want;
            if (owed_results.size() == 0) begin
                errors++;
                $display("%0t: result with none expected, byte %h status %0d",
                         $time, got_byte, got_status);
                return;
            end
            want = owed_results.pop_front();
            if (got_byte !== want.out_byte || got_status !== want.status) begin
                errors++;
                $display("%0t: mismatch, expected byte %h status %0d, actual byte %h status %0d",
                         $time, want.out_byte, want.status, got_byte, got_status);
            end
        endfunction

        function int unsigned pending();
            return owed_results.size();
        endfunction
    endclass

    // clock, reset and core ports; every input starts at a known value
    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_stall;
    logic        in_opcode  = OP_PUSH;
    logic [7:0]  in_data    = 8'h00;
    logic        out_valid;
    logic        out_stall  = 1'b0;
    logic [7:0]  out_byte;
    logic [2:0]  out_status;
    logic        cfg_valid  = 1'b0;
    logic        cfg_ready;
    t_cfg_index  cfg_index  = CFG_BITS_BLUE;
    logic [31:0] cfg_data   = '0;

    embed_scoreboard sb = new();

    // idle control: quiet phases run both sides without gaps
    logic        tx_quiet  = 1'b0;
    logic        rx_quiet  = 1'b0;
    logic        long_hold = 1'b0;
    int unsigned rx_wait   = 0;

    localparam int unsigned LONG_HOLD_CYCLES = 64;

    lsb_variable_depth_embed_core i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_opcode    (in_opcode),
        .i_data_byte (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_byte  (out_byte),
        .o_status    (out_status),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    // receiver: checks each accepted result word, then stalls for a drawn count
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                sb.check_word(out_byte, out_status);
                rx_wait = rx_quiet ? 0 : $urandom_range(0, 19);
            end
            // long hold-off so the result register fills and the input backs up
            if (long_hold) begin
                rx_wait   = LONG_HOLD_CYCLES;
                long_hold = 1'b0;
            end
            if (rx_wait != 0) begin
                out_stall <= 1'b1;
                rx_wait--;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // offer one input word after a drawn gap and hold it until accepted
    task automatic send_word(logic op, logic [7:0] data);
        int unsigned gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        in_opcode <= op;
        in_data   <= data;
        do @(posedge clk); while (!(in_valid && !in_stall));
        sb.note_word(op, data);
    endtask

    // stop offering words until every owed result has come back
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
        // the core has only one result register to drain
        repeat (2) @(posedge clk);
    endtask

    // valid stays high across back-to-back register writes
    task automatic write_reg(t_cfg_index idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, val);
    endtask

    task automatic write_config(logic [31:0] blue, logic [31:0] green, logic [31:0] red,
                                logic [31:0] skip, logic [31:0] total, logic [31:0] limit);
        write_reg(CFG_BITS_BLUE, blue);
        write_reg(CFG_BITS_GREEN, green);
        write_reg(CFG_BITS_RED, red);
        write_reg(CFG_SKIP_PIXELS, skip);
        write_reg(CFG_SECRET_TOTAL, total);
        write_reg(CFG_PAYLOAD_LIMIT, limit);
        cfg_valid <= 1'b0;
    endtask

    // depth register value: mostly 1..8, sometimes zero or above eight,
    // with random junk in the unused upper bits
    function automatic logic [31:0] pick_depth();
        logic [31:0] junk;
        int unsigned r;
        logic [3:0]  d;
        junk = $urandom();
        r    = $urandom_range(0, 9);
        if (r == 0)      d = 4'd0;
        else if (r == 1) d = 4'($urandom_range(9, 15));
        else             d = 4'($urandom_range(1, 8));
        return {junk[31:4], d};
    endfunction

    initial begin : stimulus
        logic [31:0] blue, green, red, skip, total, limit;
        logic        op;
        int unsigned r;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: nothing to embed, push dropped and cover passed
        send_word(OP_PUSH, 8'hA5);
        send_word(OP_COVER, 8'hFF);
        drain();

        // full depth blue, zero depth green, red above eight, three bytes total
        write_config(32'd8, 32'd0, 32'd12, 32'd0, 32'd3, 32'd1000);
        send_word(OP_PUSH, 8'h00);
        send_word(OP_PUSH, 8'hFF);
        send_word(OP_PUSH, 8'h5A);   // buffer full, dropped
        send_word(OP_COVER, 8'hFF);  // takes eight zero bits
        send_word(OP_COVER, 8'h00);  // zero depth passes
        send_word(OP_COVER, 8'hAA);  // takes eight one bits
        send_word(OP_COVER, 8'h3C);  // nothing held, zero-filled
        send_word(OP_COVER, 8'h77);  // secret total used up
        send_word(OP_PUSH, 8'h11);   // push beyond total
        drain();

        // small depths with pixel skipping and underflow
        write_config(32'd1, 32'd3, 32'd5, 32'd1, sb.bytes_used + 32'd2,
                     sb.channels_seen + 32'd8);
        send_word(OP_PUSH, 8'hC3);
        send_word(OP_COVER, 8'h80);
        send_word(OP_COVER, 8'h7F);
        send_word(OP_COVER, 8'h01);
        send_word(OP_COVER, 8'hFE);
        send_word(OP_COVER, 8'h55);
        send_word(OP_COVER, 8'hAA);
        send_word(OP_COVER, 8'h0F);
        send_word(OP_COVER, 8'hF0);

        for (int ph = 0; ph < 9; ph++) begin
            drain();
            tx_quiet = (ph % 3 == 1);
            rx_quiet = (ph % 3 == 1);
            blue  = pick_depth();
            green = pick_depth();
            red   = pick_depth();
            skip  = $urandom_range(0, 2);
            total = sb.bytes_used + $urandom_range(2, 24);
            limit = sb.channels_seen + $urandom_range(20, 90);
            case (ph)
                2: begin
                    // widest settings
                    blue  = {blue[31:4], 4'd8};
                    green = {green[31:4], 4'd8};
                    red   = {red[31:4], 4'd8};
                    skip  = 32'd0;
                    total = '1;
                    limit = '1;
                end
                5: begin
                    blue  = {blue[31:4], 4'd0};
                    green = {green[31:4], 4'd15};
                    red   = {red[31:4], 4'd9};
                end
                6: limit = 32'd0;
                // longest skip last: once it starts nothing embeds again
                8: skip = '1;
                default: ;
            endcase
            write_config(blue, green, red, skip, total, limit);
            for (int i = 0; i < 42; i++) begin
                if (ph == 4 && i == 8) long_hold = 1'b1;
                if (ph == 3 && i == 20) drain();
                // keep the buffer fed most of the time, with a few overfull pushes
                r = $urandom_range(0, 99);
                if (sb.bits_held <= 5'd8) op = (r < 45) ? OP_PUSH : OP_COVER;
                else                      op = (r < 5) ? OP_PUSH : OP_COVER;
                send_word(op, 8'($urandom()));
            end
        end

        drain();
        repeat (4) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // run limit, far beyond the slowest passing run
    initial begin : watchdog
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
